// File: rtl/ofd_pkg.sv
// Shared constants for the overflow reporting drain FIFO.
package ofd_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int MAX_BURST       = 16;

    localparam logic [31:0] REPORT_CODE       = 32'h0000_000c;
    localparam logic [31:0] REPORT_COUNT_MASK = 32'h00ff_ff00;

    localparam logic [1:0] REG_OCC_CEILING = 2'd0;
    localparam logic [1:0] REG_BURST_CAP   = 2'd1;
    localparam logic [1:0] REG_ERROR_TAG   = 2'd2;

    localparam logic [7:0]  OCC_CEILING_RST = 8'd2;
    localparam logic [4:0]  BURST_CAP_RST   = 5'd4;
    localparam logic [31:0] ERROR_TAG_RST   = 32'd0;

endpackage

// File: rtl/overflow_reporting_drain_fifo.sv
// Top level: word FIFO with drop counter, overflow report and occupancy-limited drain.
//
// Enqueue words (s_tuser 0) are written into the FIFO; a word arriving while the FIFO is full is
// dropped, counted and flagged. A service word (s_tuser 1) holds the block while it sends n
// words (n at most min(send limit, 16)), or none, and while the output stalls: each sent word
// is first read from the FIFO memory (registered read) and then loaded into the output
// register. After the burst the pending overflow report, if any, is written into the FIFO if
// it is then under half full, else it stays pending. The output register lets the next input
// word be taken while the last sent word still waits.
module overflow_reporting_drain_fifo #(
    parameter int QUEUE_DEPTH = ofd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // word[31:0], ring_occupancy[39:32]
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // sent_word[31:0]
    output logic        m_tlast,   // last_of_burst
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int ADDR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0]  HALF_CNT  = CNT_W'(QUEUE_DEPTH / 2);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(QUEUE_DEPTH - 1);
    localparam logic [4:0]        BURST_MAX = 5'(ofd_pkg::MAX_BURST);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DRAIN  = 2'd1;
    localparam logic [1:0] ST_READ   = 2'd2;
    localparam logic [1:0] ST_REPORT = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [ADDR_W-1:0] rp_reg, rp_next;
    logic [ADDR_W-1:0] wp_reg, wp_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic              pending_reg, pending_next;
    logic [15:0]       drops_reg, drops_next;
    logic [7:0]        max_occ_reg, max_occ_next;
    logic [4:0]        tries_reg, tries_next;
    logic [31:0]       tag_reg, tag_next;
    logic [7:0]        occ_reg, occ_next;
    logic [4:0]        limit_reg, limit_next;
    logic [4:0]        sent_reg, sent_next;
    logic              out_valid_reg, out_valid_next;
    logic [31:0]       out_data_reg, out_data_next;
    logic              out_last_reg, out_last_next;

    logic              ram_wr_en;
    logic [31:0]       ram_wr_data;
    logic              ram_rd_en;
    logic [31:0]       ram_rd_data;

    logic              can_send;
    logic              out_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tlast   = out_last_reg;
    assign out_free  = !out_valid_reg || m_tready;

    assign can_send = (sent_reg < limit_reg) && (fill_reg != '0)
                      && ({1'b0, occ_reg} + {4'd0, sent_reg} < {1'b0, max_occ_reg});

    always_comb
    begin
        state_next     = state_reg;
        rp_next        = rp_reg;
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        pending_next   = pending_reg;
        drops_next     = drops_reg;
        max_occ_next   = max_occ_reg;
        tries_next     = tries_reg;
        tag_next       = tag_reg;
        occ_next       = occ_reg;
        limit_next     = limit_reg;
        sent_next      = sent_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        ram_wr_en      = 1'b0;
        ram_wr_data    = s_tdata[31:0];
        ram_rd_en      = 1'b0;

        if (cfg_valid)
        begin
            case (cfg_index)
                ofd_pkg::REG_OCC_CEILING: max_occ_next = cfg_data[7:0];
                ofd_pkg::REG_BURST_CAP:   tries_next   = cfg_data[4:0];
                ofd_pkg::REG_ERROR_TAG:   tag_next     = cfg_data;
                default:                  ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (!s_tuser)
                    begin
                        if (fill_reg >= FULL_CNT)
                        begin
                            pending_next = 1'b1;
                            drops_next   = drops_reg + 16'd1;
                        end
                        else
                        begin
                            ram_wr_en = 1'b1;
                            wp_next   = (wp_reg == LAST_ADDR) ? '0 : wp_reg + ADDR_W'(1);
                            fill_next = fill_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        occ_next   = s_tdata[39:32];
                        limit_next = (tries_reg > BURST_MAX) ? BURST_MAX : tries_reg;
                        sent_next  = '0;
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (can_send)
                begin
                    ram_rd_en  = 1'b1;
                    rp_next    = (rp_reg == LAST_ADDR) ? '0 : rp_reg + ADDR_W'(1);
                    fill_next  = fill_reg - CNT_W'(1);
                    sent_next  = sent_reg + 5'd1;
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = ram_rd_data;
                    out_last_next  = !can_send;
                    state_next     = can_send ? ST_DRAIN : ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                if (pending_reg && (fill_reg < HALF_CNT))
                begin
                    ram_wr_en    = 1'b1;
                    ram_wr_data  = tag_reg | ofd_pkg::REPORT_CODE
                                   | (({16'd0, drops_reg} << 8) & ofd_pkg::REPORT_COUNT_MASK);
                    wp_next      = (wp_reg == LAST_ADDR) ? '0 : wp_reg + ADDR_W'(1);
                    fill_next    = fill_reg + CNT_W'(1);
                    pending_next = 1'b0;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rp_reg        <= '0;
            wp_reg        <= '0;
            fill_reg      <= '0;
            pending_reg   <= 1'b0;
            drops_reg     <= '0;
            max_occ_reg   <= ofd_pkg::OCC_CEILING_RST;
            tries_reg     <= ofd_pkg::BURST_CAP_RST;
            tag_reg       <= ofd_pkg::ERROR_TAG_RST;
            limit_reg     <= '0;
            sent_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            pending_reg   <= pending_next;
            drops_reg     <= drops_next;
            max_occ_reg   <= max_occ_next;
            tries_reg     <= tries_next;
            tag_reg       <= tag_next;
            limit_reg     <= limit_next;
            sent_reg      <= sent_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        occ_reg      <= occ_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    ofd_ram #(
        .WIDTH (32),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (wp_reg),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (rp_reg),
        .rd_data (ram_rd_data)
    );

endmodule

// File: rtl/ofd_ram.sv
// Generic single write port, single read port RAM with registered read.
module ofd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
